[rtl/core/qsk_pkg.sv]
package qsk_pkg;

   // default build parameters
   localparam int QSK_DEPTH   = 64;
   localparam int QSK_ID_BITS = 20;

   // fixed field widths on the stream ports
   localparam int ID_W     = 20;
   localparam int RATING_W = 9;
   localparam int SWAP_W   = 12;
   localparam int PART_W   = 6;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_PAD_W  = RSP_DATA_W - (ID_W + RATING_W + SWAP_W + PART_W);

   localparam logic [SWAP_W-1:0] SWAP_MAX = {SWAP_W{1'b1}};

   // memory port strobes
   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctl_type;

   // sort sequencer states
   typedef enum logic [3:0] {
      S_LOAD,
      S_POP,
      S_POPW,
      S_PIVOT,
      S_PIVCAP,
      S_READ,
      S_EVAL,
      S_READ2,
      S_SWAP1,
      S_SWAP2,
      S_FSWAP1,
      S_FSWAP2,
      S_PDONE,
      S_PUSH2,
      S_EMIT_RD,
      S_EMIT
   } state_type;

endpackage

[rtl/core/qsk_rec_ram.sv]
module qsk_rec_ram #(
   parameter int DEPTH = qsk_pkg::QSK_DEPTH,
   parameter int WIDTH = qsk_pkg::QSK_ID_BITS + qsk_pkg::RATING_W
) (
   input  logic                       clock,
   input  qsk_pkg::ram_ctl_type       ctl,
   input  logic [$clog2(DEPTH)-1:0]   waddr,
   input  logic [WIDTH-1:0]           wdata,
   input  logic [$clog2(DEPTH)-1:0]   raddr_a,
   input  logic [$clog2(DEPTH)-1:0]   raddr_b,
   output logic [WIDTH-1:0]           rdata_a,
   output logic [WIDTH-1:0]           rdata_b
);
   import qsk_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[waddr] <= wdata;
      end
      if (ctl.rd_en) begin
         rdata_a_ff <= mem_ff[raddr_a];
         rdata_b_ff <= mem_ff[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

[rtl/core/qsk_stack_ram.sv]
module qsk_stack_ram #(
   parameter int DEPTH = qsk_pkg::QSK_DEPTH,
   parameter int WIDTH = 2 * $clog2(qsk_pkg::QSK_DEPTH)
) (
   input  logic                       clock,
   input  qsk_pkg::ram_ctl_type       ctl,
   input  logic [$clog2(DEPTH)-1:0]   waddr,
   input  logic [WIDTH-1:0]           wdata,
   input  logic [$clog2(DEPTH)-1:0]   raddr,
   output logic [WIDTH-1:0]           rdata
);
   import qsk_pkg::*;

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // range stack storage, registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[waddr] <= wdata;
      end
      if (ctl.rd_en) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/core/record_quicksort_by_key.sv]
// loading takes one record per cycle; the beat marked last starts the sort
// sort: range pop S_POP, S_POPW; pivot fetch S_PIVOT, S_PIVCAP; scan step S_READ, S_EVAL;
// a swap adds S_READ2, S_SWAP1, S_SWAP2; closing pivot swap S_FSWAP1, S_FSWAP2;
// partition end S_PDONE, S_PUSH2; each result is a memory read, then a beat
// reset is synchronous and clears the sequencer, counters and stack pointer;
// record and stack memories are not cleared, so no clearing pass is needed
module record_quicksort_by_key #(
   parameter int DEPTH   = qsk_pkg::QSK_DEPTH,
   parameter int ID_BITS = qsk_pkg::QSK_ID_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [19:0] record_id, [28:20] rating, [31:29] zero
   input  logic [qsk_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [19:0] sorted_id, [28:20] sorted_rating, [40:29] swap_total,
   // [46:41] partition_total, [47] zero
   output logic [qsk_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast
);
   import qsk_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int REC_W = ID_BITS + RATING_W;
   localparam int STK_W = 2 * IDX_W;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  top_ff, top_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [IDX_W-1:0]  lo_ff, lo_in;
   logic [IDX_W-1:0]  hi_ff, hi_in;
   logic [IDX_W-1:0]  i_ff, i_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   logic [REC_W-1:0]  piv_ff, piv_in;
   logic [SWAP_W-1:0] swap_ff, swap_in;
   logic [PART_W-1:0] part_ff, part_in;

   // record memory port
   ram_ctl_type       rec_ctl;
   logic [IDX_W-1:0]  rec_waddr;
   logic [REC_W-1:0]  rec_wdata;
   logic [IDX_W-1:0]  rec_raddr_a;
   logic [IDX_W-1:0]  rec_raddr_b;
   logic [REC_W-1:0]  rec_rdata_a;
   logic [REC_W-1:0]  rec_rdata_b;

   // stack memory port
   ram_ctl_type       stk_ctl;
   logic [IDX_W-1:0]  stk_waddr;
   logic [STK_W-1:0]  stk_wdata;
   logic [IDX_W-1:0]  stk_raddr;
   logic [STK_W-1:0]  stk_rdata;

   // helpers
   logic [ID_BITS-1:0]  id_keep;
   logic [RATING_W-1:0] rating_in;
   logic [CNT_W-1:0]    n_new;
   logic [CNT_W-1:0]    n_dec;
   logic [CNT_W-1:0]    top_dec;
   logic [CNT_W-1:0]    k_inc;
   logic [IDX_W-1:0]    pop_lo;
   logic [IDX_W-1:0]    pop_hi;
   logic [IDX_W-1:0]    j_nxt;
   logic [IDX_W-1:0]    i_nxt;
   logic [IDX_W-1:0]    i_dec;
   logic [IDX_W:0]      i_nxt_w;
   logic [IDX_W:0]      lo_nxt_w;
   logic [RATING_W-1:0] key_i;
   logic [RATING_W-1:0] key_j;
   logic [RATING_W-1:0] key_p;
   logic                fin;

   assign id_keep   = ID_BITS'(req_tdata[ID_W-1:0]);
   assign rating_in = req_tdata[ID_W +: RATING_W];
   assign top_dec   = top_ff - CNT_W'(1);
   assign k_inc     = k_ff + CNT_W'(1);
   assign pop_lo    = stk_rdata[STK_W-1:IDX_W];
   assign pop_hi    = stk_rdata[IDX_W-1:0];
   assign j_nxt     = j_ff + IDX_W'(1);
   assign i_nxt     = i_ff + IDX_W'(1);
   assign i_dec     = i_ff - IDX_W'(1);
   assign i_nxt_w   = (IDX_W+1)'(i_ff) + (IDX_W+1)'(1);
   assign lo_nxt_w  = (IDX_W+1)'(lo_ff) + (IDX_W+1)'(1);
   assign key_i     = rec_rdata_a[REC_W-1:ID_BITS];
   assign key_j     = rec_rdata_b[REC_W-1:ID_BITS];
   assign key_p     = piv_ff[REC_W-1:ID_BITS];
   assign fin       = (k_inc == count_ff);

   qsk_rec_ram #(
      .DEPTH (DEPTH),
      .WIDTH (REC_W)
   ) u_rec_ram (
      .clock   (clock),
      .ctl     (rec_ctl),
      .waddr   (rec_waddr),
      .wdata   (rec_wdata),
      .raddr_a (rec_raddr_a),
      .raddr_b (rec_raddr_b),
      .rdata_a (rec_rdata_a),
      .rdata_b (rec_rdata_b)
   );

   qsk_stack_ram #(
      .DEPTH (DEPTH),
      .WIDTH (STK_W)
   ) u_stack_ram (
      .clock (clock),
      .ctl   (stk_ctl),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         top_ff   <= '0;
         k_ff     <= '0;
         lo_ff    <= '0;
         hi_ff    <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         swap_ff  <= '0;
         part_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         top_ff   <= top_in;
         k_ff     <= k_in;
         lo_ff    <= lo_in;
         hi_ff    <= hi_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         swap_ff  <= swap_in;
         part_ff  <= part_in;
      end
   end

   // pivot record
   always_ff @(posedge clock) begin
      piv_ff <= piv_in;
   end

   // sequencer: load, partition loop comparing against the pivot key, emit
   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      top_in      = top_ff;
      k_in        = k_ff;
      lo_in       = lo_ff;
      hi_in       = hi_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      piv_in      = piv_ff;
      swap_in     = swap_ff;
      part_in     = part_ff;
      rec_ctl     = '0;
      rec_waddr   = i_ff;
      rec_wdata   = rec_rdata_b;
      rec_raddr_a = i_ff;
      rec_raddr_b = j_ff;
      stk_ctl     = '0;
      stk_waddr   = top_ff[IDX_W-1:0];
      stk_wdata   = {i_nxt, hi_ff};
      stk_raddr   = top_dec[IDX_W-1:0];
      req_tready  = 1'b0;
      rsp_tvalid  = 1'b0;
      n_new       = count_ff;
      n_dec       = count_ff - CNT_W'(1);

      case (state_ff)
         S_LOAD: begin
            req_tready = 1'b1;
            if (count_ff < CNT_W'(DEPTH)) begin
               n_new = count_ff + CNT_W'(1);
            end
            n_dec = n_new - CNT_W'(1);
            if (req_tvalid) begin
               // store the record unless the store is full
               if (count_ff < CNT_W'(DEPTH)) begin
                  rec_ctl.wr_en = 1'b1;
                  rec_waddr     = count_ff[IDX_W-1:0];
                  rec_wdata     = {rating_in, id_keep};
               end
               count_in = n_new;
               if (req_tlast) begin
                  swap_in = '0;
                  part_in = '0;
                  k_in    = '0;
                  if (n_new < CNT_W'(2)) begin
                     state_in = S_EMIT_RD;
                  end else begin
                     // whole set as the first range
                     stk_ctl.wr_en = 1'b1;
                     stk_waddr     = '0;
                     stk_wdata     = {IDX_W'(0), n_dec[IDX_W-1:0]};
                     top_in        = CNT_W'(1);
                     state_in      = S_POP;
                  end
               end
            end
         end
         S_POP: begin
            if (top_ff == '0) begin
               state_in = S_EMIT_RD;
            end else begin
               stk_ctl.rd_en = 1'b1;
               top_in        = top_dec;
               state_in      = S_POPW;
            end
         end
         S_POPW: begin
            // skip empty or out-of-set ranges
            if (pop_lo >= pop_hi || CNT_W'(pop_hi) >= count_ff) begin
               state_in = S_POP;
            end else begin
               lo_in    = pop_lo;
               hi_in    = pop_hi;
               i_in     = pop_lo;
               j_in     = pop_lo;
               state_in = S_PIVOT;
            end
         end
         S_PIVOT: begin
            rec_ctl.rd_en = 1'b1;
            rec_raddr_a   = hi_ff;
            state_in      = S_PIVCAP;
         end
         S_PIVCAP: begin
            piv_in   = rec_rdata_a;
            state_in = S_READ;
         end
         S_READ: begin
            rec_ctl.rd_en = 1'b1;
            state_in      = S_EVAL;
         end
         S_EVAL: begin
            if (key_i <= key_p && key_j <= key_p) begin
               // both in the low part: advance together
               i_in     = i_nxt;
               j_in     = j_nxt;
               state_in = (j_nxt == hi_ff) ? S_PDONE : S_READ;
            end else if (key_j > key_p) begin
               if (j_nxt == hi_ff) begin
                  state_in = S_FSWAP1;
               end else begin
                  j_in     = j_nxt;
                  state_in = S_READ2;
               end
            end else begin
               state_in = S_PDONE;
            end
         end
         S_READ2: begin
            rec_ctl.rd_en = 1'b1;
            state_in      = S_SWAP1;
         end
         S_SWAP1: begin
            rec_ctl.wr_en = 1'b1;
            rec_waddr     = i_ff;
            rec_wdata     = rec_rdata_b;
            swap_in       = (swap_ff == SWAP_MAX) ? swap_ff : swap_ff + SWAP_W'(1);
            state_in      = S_SWAP2;
         end
         S_SWAP2: begin
            rec_ctl.wr_en = 1'b1;
            rec_waddr     = j_ff;
            rec_wdata     = rec_rdata_a;
            if (key_j <= key_p) begin
               i_in = i_nxt;
            end
            state_in = S_READ;
         end
         S_FSWAP1: begin
            // pivot moves to i
            rec_ctl.wr_en = 1'b1;
            rec_waddr     = i_ff;
            rec_wdata     = piv_ff;
            swap_in       = (swap_ff == SWAP_MAX) ? swap_ff : swap_ff + SWAP_W'(1);
            state_in      = S_FSWAP2;
         end
         S_FSWAP2: begin
            rec_ctl.wr_en = 1'b1;
            rec_waddr     = hi_ff;
            rec_wdata     = rec_rdata_a;
            state_in      = S_PDONE;
         end
         S_PDONE: begin
            part_in = part_ff + PART_W'(1);
            // upper subrange
            if (i_nxt_w < (IDX_W+1)'(hi_ff) && top_ff < CNT_W'(DEPTH)) begin
               stk_ctl.wr_en = 1'b1;
               stk_wdata     = {i_nxt, hi_ff};
               top_in        = top_ff + CNT_W'(1);
            end
            state_in = S_PUSH2;
         end
         S_PUSH2: begin
            // lower subrange, popped first
            if ((IDX_W+1)'(i_ff) > lo_nxt_w && top_ff < CNT_W'(DEPTH)) begin
               stk_ctl.wr_en = 1'b1;
               stk_wdata     = {lo_ff, i_dec};
               top_in        = top_ff + CNT_W'(1);
            end
            state_in = S_POP;
         end
         S_EMIT_RD: begin
            rec_ctl.rd_en = 1'b1;
            rec_raddr_a   = k_ff[IDX_W-1:0];
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            rsp_tvalid = 1'b1;
            if (rsp_tready) begin
               k_in = k_inc;
               if (fin) begin
                  count_in = '0;
                  state_in = S_LOAD;
               end else begin
                  state_in = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // result beat
   assign rsp_tlast = fin;
   assign rsp_tdata = {
      {RSP_PAD_W{1'b0}},
      fin ? part_ff : PART_W'(0),
      fin ? swap_ff : SWAP_W'(0),
      rec_rdata_a[REC_W-1:ID_BITS],
      ID_W'(rec_rdata_a[ID_BITS-1:0])
   };

   // scan indexes stay ordered inside the range
   a_scan_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL) |-> (i_ff <= j_ff && j_ff < hi_ff))
      else $error("scan indexes out of order");

   // a partitioned range is non-empty and inside the loaded set
   a_range_ok: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PIVOT) |-> (lo_ff < hi_ff && CNT_W'(hi_ff) < count_ff))
      else $error("bad range popped");

   // the final beat empties the store and reopens the input
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (req_tready && count_ff == '0))
      else $error("run did not close after final beat");

   // no input beat taken while results are pending
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input open during emit");

   // stack pointer never passes the depth
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      (top_ff != $past(top_ff)) |-> (top_ff <= CNT_W'(DEPTH)))
      else $error("range stack overflow");

endmodule

[verif/tb_record_quicksort_by_key.sv]
`timescale 1ns / 1ps

import qsk_pkg::*;

// one sorted record as it leaves the block
typedef struct packed {
   logic [ID_W-1:0]     id;
   logic [RATING_W-1:0] rating;
   logic                fin;
   logic [SWAP_W-1:0]   swaps;
   logic [PART_W-1:0]   parts;
} sorted_rec_type;

// how the ratings of one record set are chosen
typedef enum int {
   FILL_RANDOM,
   FILL_CLUSTER,
   FILL_RISING,
   FILL_FALLING
} fill_mode_type;

// holds the loaded records, sorts them the way the block does and checks its output
class sorted_record_board;
   logic [RATING_W+ID_W-1:0] held [QSK_DEPTH];
   int unsigned held_n = 0;
   int unsigned swap_cnt = 0;
   int unsigned part_cnt = 0;
   int unsigned beats_seen = 0;
   int unsigned mismatches = 0;
   sorted_rec_type pending_sorted [$];

   function logic [RATING_W-1:0] key_of(int unsigned k);
      return held[k][RATING_W+ID_W-1:ID_W];
   endfunction

   function void exchange(int unsigned a, int unsigned b);
      logic [RATING_W+ID_W-1:0] t;
      t = held[a];
      held[a] = held[b];
      held[b] = t;
      if (swap_cnt < SWAP_MAX) swap_cnt++;
   endfunction

   // two-index partition around the last element; returns the pivot's final place
   function int unsigned split_range(int unsigned lo, int unsigned hi);
      int unsigned i, j;
      logic [RATING_W-1:0] piv;
      i = lo;
      j = lo;
      piv = key_of(hi);
      while (j != hi) begin
         if (key_of(i) <= piv && key_of(j) <= piv) begin
            i++;
            j++;
         end else if (key_of(j) > piv) begin
            j++;
            if (j == hi) begin
               exchange(i, hi);
               break;
            end
            exchange(i, j);
            if (key_of(i) <= piv) i++;
         end else begin
            break;
         end
      end
      return i;
   endfunction

   // quicksort over held[0..n-1] with an explicit range stack
   function void sort_held(int unsigned n);
      int unsigned range_lo [QSK_DEPTH];
      int unsigned range_hi [QSK_DEPTH];
      int unsigned top, lo, hi, p;
      swap_cnt = 0;
      part_cnt = 0;
      top = 0;
      if (n < 2) return;
      range_lo[0] = 0;
      range_hi[0] = n - 1;
      top = 1;
      while (top > 0) begin
         top--;
         lo = range_lo[top];
         hi = range_hi[top];
         if (lo >= hi || hi >= n) continue;
         p = split_range(lo, hi);
         part_cnt = (part_cnt + 1) & ((1 << PART_W) - 1);
         if (p + 1 < hi && top < QSK_DEPTH) begin
            range_lo[top] = p + 1;
            range_hi[top] = hi;
            top++;
         end
         if (p > lo + 1 && top < QSK_DEPTH) begin
            range_lo[top] = lo;
            range_hi[top] = p - 1;
            top++;
         end
      end
   endfunction

   // accepted input beat: store it, and on the last one queue the sorted set
   function void note_record(logic [ID_W-1:0] id, logic [RATING_W-1:0] rating, logic last);
      sorted_rec_type r;
      if (held_n < QSK_DEPTH) begin
         held[held_n] = {rating, id};
         held_n++;
      end
      if (!last) return;
      sort_held(held_n);
      for (int unsigned k = 0; k < held_n; k++) begin
         r.id     = held[k][ID_W-1:0];
         r.rating = held[k][RATING_W+ID_W-1:ID_W];
         r.fin    = (k + 1 == held_n);
         r.swaps  = r.fin ? swap_cnt[SWAP_W-1:0] : '0;
         r.parts  = r.fin ? part_cnt[PART_W-1:0] : '0;
         pending_sorted = {pending_sorted, r};
      end
      held_n = 0;
   endfunction

   task report(string msg);
      mismatches++;
      $display("[%0t] result beat %0d: %s", $realtime, beats_seen, msg);
   endtask

   task check_field(string name, int unsigned want, int unsigned got);
      if (want != got) report($sformatf("%s expected %0d, got %0d", name, want, got));
   endtask

   // accepted result beat against the oldest expected record
   task check_result(logic [RSP_DATA_W-1:0] data, logic last);
      sorted_rec_type want;
      if (pending_sorted.size() == 0) begin
         report("result beat with nothing expected");
      end else begin
         want = pending_sorted.pop_front();
         check_field("sorted_id", want.id, data[ID_W-1:0]);
         check_field("sorted_rating", want.rating, data[ID_W+RATING_W-1:ID_W]);
         check_field("final_result", want.fin, last);
         check_field("swap_total", want.swaps, data[ID_W+RATING_W+SWAP_W-1:ID_W+RATING_W]);
         check_field("partition_total", want.parts,
                     data[ID_W+RATING_W+SWAP_W+PART_W-1:ID_W+RATING_W+SWAP_W]);
      end
      beats_seen++;
   endtask
endclass

module tb_record_quicksort_by_key;

   localparam int CYCLE_LIMIT = 500000;
   localparam int ITEM_TARGET = 230;
   localparam int DRAIN_CYCLES = 200;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;

   sorted_record_board board = new();
   int unsigned records_sent = 0;
   int unsigned cycles = 0;
   bit sender_calm = 1'b0;
   bit receiver_calm = 1'b0;
   int unsigned stall_left = 0;

   record_quicksort_by_key u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // run guard
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("record_quicksort_by_key verification failed");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // result side stalls
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!receiver_calm && $urandom_range(0, 3) == 0) begin
         rsp_tready <= 1'b0;
         stall_left = pick_gap();
      end else begin
         rsp_tready <= 1'b1;
      end
      if ($urandom_range(0, 149) == 0) receiver_calm = !receiver_calm;
   end

   // result beats
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_result(rsp_tdata, rsp_tlast);
   end

   // one record beat, after an optional idle gap
   task send_record(logic [ID_W-1:0] id, logic [RATING_W-1:0] rating, logic last);
      int unsigned gap;
      gap = sender_calm ? 0 : pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {{(REQ_DATA_W - ID_W - RATING_W){1'b0}}, rating, id};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      board.note_record(id, rating, last);
      records_sent++;
   endtask

   // a whole record set of n beats, last one flagged
   task send_set(int unsigned n, fill_mode_type mode);
      int unsigned base;
      logic [RATING_W-1:0] rating;
      base = $urandom_range(0, 497);
      sender_calm = ($urandom_range(0, 4) == 0);
      for (int unsigned k = 0; k < n; k++) begin
         case (mode)
            FILL_CLUSTER: rating = RATING_W'(base + $urandom_range(0, 3));
            FILL_RISING:  rating = RATING_W'(k * 7);
            FILL_FALLING: rating = RATING_W'(500 - k * 7);
            default:      rating = RATING_W'($urandom_range(0, 500));
         endcase
         send_record(ID_W'($urandom()), rating, k + 1 == n);
      end
   endtask

   initial begin
      int unsigned set_no;
      fill_mode_type mode;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: single records, id and rating extremes, keys above 500
      send_record(20'hFFFFF, 9'd500, 1'b1);
      send_record(20'h00000, 9'd0, 1'b1);
      send_record(20'h12345, 9'd511, 1'b0);
      send_record(20'hABCDE, 9'd0, 1'b1);
      send_record(20'h00001, 9'd0, 1'b0);
      send_record(20'h00002, 9'd500, 1'b1);
      // equal keys
      for (int unsigned k = 0; k < 4; k++) send_record(ID_W'(20'h50 + k), 9'd250, k == 3);
      // falling keys across the bit-8 boundary
      send_record(20'h0A001, 9'd509, 1'b0);
      send_record(20'h0A002, 9'd400, 1'b0);
      send_record(20'h0A003, 9'd256, 1'b0);
      send_record(20'h0A004, 9'd255, 1'b0);
      send_record(20'h0A005, 9'd1, 1'b1);
      // duplicates among mixed keys
      send_record(20'h55555, 9'd3, 1'b0);
      send_record(20'hAAAAA, 9'd0, 1'b0);
      send_record(20'h0F0F0, 9'd3, 1'b0);
      send_record(20'hF0F0F, 9'd501, 1'b0);
      send_record(20'h00000, 9'd0, 1'b1);

      // random sets; one full store and one overfull store among them
      set_no = 0;
      while (records_sent < ITEM_TARGET) begin
         if (set_no == 3) begin
            send_set(QSK_DEPTH, FILL_RISING);
         end else if (set_no == 8) begin
            send_set(QSK_DEPTH + 2, FILL_RANDOM);
         end else begin
            mode = fill_mode_type'($urandom_range(0, 3));
            send_set($urandom_range(1, 12), mode);
         end
         set_no++;
      end
      @(negedge clock);
      req_tvalid <= 1'b0;
      req_tlast <= 1'b0;

      // drain
      while (board.pending_sorted.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0 && board.pending_sorted.size() == 0) begin
         $display("record_quicksort_by_key verification clean");
      end else begin
         $display("record_quicksort_by_key verification failed");
      end
      $finish;
   end

endmodule
